>>> design/urds_pkg.sv
// Shared types, constants and register indexes of the ultrasonic ranging duty sequencer.
package urds_pkg;

  localparam int NUM_CHANNELS_DEF = 4;
  localparam int COUNT_BITS_DEF   = 16;

  localparam int CH_W     = 2;
  localparam int ECHO_W   = 4;
  localparam int CM_W     = 16;
  localparam int DUTY_W   = 8;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;
  // Widest duty divisor: gain_den (8 bits) times distance (16 bits).
  localparam int DVS_W    = 24;

  localparam logic [CM_W-1:0]   CM_MAX   = 16'hFFFF;
  localparam logic [DUTY_W-1:0] DUTY_MAX = 8'hFF;

  localparam logic [CFG_IDX_W-1:0] REG_TRIGGER_TICKS = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TICKS_PER_CM  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_NUM      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_DEN      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_DUTY_OFFSET   = 3'd4;

  localparam logic [7:0]  TRIGGER_TICKS_RST = 8'd10;
  localparam logic [7:0]  TICKS_PER_CM_RST  = 8'd58;
  localparam logic [15:0] GAIN_NUM_RST      = 16'd128;
  localparam logic [7:0]  GAIN_DEN_RST      = 8'd3;
  localparam logic [7:0]  DUTY_OFFSET_RST   = 8'd13;

  typedef enum logic [1:0] {
    PH_TRIG = 2'd0,
    PH_WAIT = 2'd1,
    PH_MEAS = 2'd2
  } phase_e;

  typedef enum logic [2:0] {
    C_IDLE,
    C_DIV1,
    C_MUL,
    C_DIV2S,
    C_DIV2,
    C_FIN
  } ctrl_e;

  typedef struct packed {
    logic step;
    logic out_load_tick;
    logic div_start;
    logic div_sel;
    logic cm_load;
    logic mul_load;
    logic out_load_meas;
  } cmd_t;

  typedef struct packed {
    logic fin;
    logic div_done;
  } sts_t;

endpackage

>>> design/urds_div.sv
// Restoring divider that retires one quotient bit per cycle.
module urds_div #(
  parameter int DIVIDEND_W = 16,
  parameter int DIVISOR_W  = 24
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  logic [DIVIDEND_W-1:0] dividend_i,
  input  logic [DIVISOR_W-1:0]  divisor_i,
  output logic                  done_o,
  output logic [DIVIDEND_W-1:0] quotient_o
);

  localparam int CNT_W = $clog2(DIVIDEND_W + 1);

  logic [DIVISOR_W-1:0]  rem_q, rem_d;
  logic [DIVIDEND_W-1:0] quo_q, quo_d;
  logic [DIVISOR_W-1:0]  dvs_q, dvs_d;
  logic [CNT_W-1:0]      cnt_q, cnt_d;
  logic                  busy_q, busy_d;
  logic [DIVISOR_W+1:0]  trial;

  // Two guard bits so that the borrow shows in the top bit.
  assign trial = {1'b0, rem_q, quo_q[DIVIDEND_W-1]} - {2'b00, dvs_q};

  always_comb begin
    rem_d  = rem_q;
    quo_d  = quo_q;
    dvs_d  = dvs_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    if (start_i) begin
      rem_d  = '0;
      quo_d  = dividend_i;
      dvs_d  = divisor_i;
      cnt_d  = CNT_W'(DIVIDEND_W);
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (!trial[DIVISOR_W+1]) begin
        rem_d = trial[DIVISOR_W-1:0];
        quo_d = {quo_q[DIVIDEND_W-2:0], 1'b1};
      end else begin
        rem_d = {rem_q[DIVISOR_W-2:0], quo_q[DIVIDEND_W-1]};
        quo_d = {quo_q[DIVIDEND_W-2:0], 1'b0};
      end
      cnt_d = cnt_q - CNT_W'(1);
      if (cnt_q == CNT_W'(1)) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    dvs_q <= dvs_d;
  end

  assign done_o     = !busy_q;
  assign quotient_o = quo_q;

endmodule

>>> design/urds_ctrl.sv
// Controller that sequences tick handling, the two divisions and the result hand-off.
module urds_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  logic            out_ready_i,
  output logic            out_valid_o,
  input  urds_pkg::sts_t  sts_i,
  output urds_pkg::cmd_t  cmd_o
);

  urds_pkg::ctrl_e state_q, state_d;
  logic            ov_q, ov_d;
  logic            slot_free;
  logic            accept;

  assign slot_free  = !ov_q || out_ready_i;
  assign in_ready_o = (state_q == urds_pkg::C_IDLE) && slot_free;
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    state_d = state_q;
    case (state_q)
      urds_pkg::C_IDLE: begin
        if (accept && sts_i.fin) state_d = urds_pkg::C_DIV1;
      end
      urds_pkg::C_DIV1: begin
        if (sts_i.div_done) state_d = urds_pkg::C_MUL;
      end
      urds_pkg::C_MUL:   state_d = urds_pkg::C_DIV2S;
      urds_pkg::C_DIV2S: state_d = urds_pkg::C_DIV2;
      urds_pkg::C_DIV2: begin
        if (sts_i.div_done) state_d = urds_pkg::C_FIN;
      end
      urds_pkg::C_FIN: begin
        if (slot_free) state_d = urds_pkg::C_IDLE;
      end
      default: state_d = urds_pkg::C_IDLE;
    endcase
  end

  always_comb begin
    cmd_o               = '0;
    cmd_o.step          = accept;
    cmd_o.out_load_tick = accept && !sts_i.fin;
    case (state_q)
      urds_pkg::C_IDLE:  cmd_o.div_start = accept && sts_i.fin;
      urds_pkg::C_DIV1:  cmd_o.cm_load = sts_i.div_done;
      urds_pkg::C_MUL:   cmd_o.mul_load = 1'b1;
      urds_pkg::C_DIV2S: begin
        cmd_o.div_start = 1'b1;
        cmd_o.div_sel   = 1'b1;
      end
      urds_pkg::C_FIN:   cmd_o.out_load_meas = slot_free;
      default: ;
    endcase
  end

  always_comb begin
    ov_d = ov_q;
    if (cmd_o.out_load_tick || cmd_o.out_load_meas) begin
      ov_d = 1'b1;
    end else if (out_ready_i) begin
      ov_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= urds_pkg::C_IDLE;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      ov_q    <= ov_d;
    end
  end

  assign out_valid_o = ov_q;

endmodule

>>> design/urds_dp.sv
// Datapath: configuration registers, channel sequencing state, divider and result registers.
module urds_dp #(
  parameter int NUM_CHANNELS = urds_pkg::NUM_CHANNELS_DEF,
  parameter int COUNT_BITS   = urds_pkg::COUNT_BITS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  urds_pkg::cmd_t                  cmd_i,
  output urds_pkg::sts_t                  sts_o,
  input  logic [urds_pkg::ECHO_W-1:0]     echo_levels_i,
  input  logic                            cfg_valid_i,
  input  logic [urds_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [urds_pkg::CFG_DATA_W-1:0] cfg_data_i,
  output logic [urds_pkg::ECHO_W-1:0]     trigger_lines_o,
  output logic                            update_valid_o,
  output logic [urds_pkg::CH_W-1:0]       update_channel_o,
  output logic [urds_pkg::CM_W-1:0]       distance_cm_o,
  output logic [urds_pkg::DUTY_W-1:0]     duty_value_o
);

  localparam int DIVW = (COUNT_BITS > urds_pkg::CM_W) ? COUNT_BITS : urds_pkg::CM_W;
  localparam int CW   = urds_pkg::CH_W;

  logic [7:0]  trigger_ticks_q, ticks_per_cm_q, gain_den_q, duty_offset_q;
  logic [15:0] gain_num_q;

  urds_pkg::phase_e      phase_q, phase_d;
  logic [CW-1:0]         ch_q, ch_d, ch_next;
  logic [COUNT_BITS-1:0] count_q, count_d, count_inc;
  logic                  echo;

  logic [CW-1:0]                   uch_q;
  logic [urds_pkg::CM_W-1:0]       cm_q, cm_sat;
  logic [urds_pkg::DVS_W-1:0]      prod_q;
  logic [DIVW-1:0]                 div_dividend, div_quo;
  logic [urds_pkg::DVS_W-1:0]      div_divisor;
  logic                            div_done;
  logic [urds_pkg::CM_W:0]         duty_sum;
  logic [urds_pkg::DUTY_W-1:0]     duty_res;

  // Configuration writes; indexes beyond the list are dropped.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      trigger_ticks_q <= urds_pkg::TRIGGER_TICKS_RST;
      ticks_per_cm_q  <= urds_pkg::TICKS_PER_CM_RST;
      gain_num_q      <= urds_pkg::GAIN_NUM_RST;
      gain_den_q      <= urds_pkg::GAIN_DEN_RST;
      duty_offset_q   <= urds_pkg::DUTY_OFFSET_RST;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        urds_pkg::REG_TRIGGER_TICKS: trigger_ticks_q <= cfg_data_i[7:0];
        urds_pkg::REG_TICKS_PER_CM:  ticks_per_cm_q  <= cfg_data_i[7:0];
        urds_pkg::REG_GAIN_NUM:      gain_num_q      <= cfg_data_i;
        urds_pkg::REG_GAIN_DEN:      gain_den_q      <= cfg_data_i[7:0];
        urds_pkg::REG_DUTY_OFFSET:   duty_offset_q   <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  assign echo      = echo_levels_i[ch_q];
  assign count_inc = count_q + COUNT_BITS'(1);
  assign ch_next   = ({1'b0, ch_q} + (CW+1)'(1) >= (CW+1)'(NUM_CHANNELS)) ? '0 : ch_q + CW'(1);

  assign sts_o.fin      = (phase_q == urds_pkg::PH_MEAS) && !echo;
  assign sts_o.div_done = div_done;

  always_comb begin
    phase_d = phase_q;
    ch_d    = ch_q;
    count_d = count_q;
    if (cmd_i.step) begin
      case (phase_q)
        urds_pkg::PH_WAIT: begin
          if (echo) begin
            count_d = COUNT_BITS'(1);
            phase_d = urds_pkg::PH_MEAS;
          end
        end
        urds_pkg::PH_MEAS: begin
          if (echo) begin
            if (count_q != '1) count_d = count_inc;
          end else begin
            count_d = '0;
            phase_d = urds_pkg::PH_TRIG;
            ch_d    = ch_next;
          end
        end
        default: begin
          // The trigger phase; a zero tick count still gives one trigger tick.
          if (count_inc >= COUNT_BITS'(trigger_ticks_q)) begin
            count_d = '0;
            phase_d = urds_pkg::PH_WAIT;
          end else begin
            count_d = count_inc;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= urds_pkg::PH_TRIG;
      ch_q    <= '0;
      count_q <= '0;
    end else begin
      phase_q <= phase_d;
      ch_q    <= ch_d;
      count_q <= count_d;
    end
  end

  // One divider serves both the distance and the duty division.
  assign div_dividend = cmd_i.div_sel ? DIVW'(gain_num_q) : DIVW'(count_q);
  assign div_divisor  = cmd_i.div_sel ? prod_q : urds_pkg::DVS_W'(ticks_per_cm_q);

  urds_div #(
    .DIVIDEND_W (DIVW),
    .DIVISOR_W  (urds_pkg::DVS_W)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .done_o     (div_done),
    .quotient_o (div_quo)
  );

  assign cm_sat = ((ticks_per_cm_q == 8'd0) || (div_quo > DIVW'(urds_pkg::CM_MAX)))
                  ? urds_pkg::CM_MAX : div_quo[urds_pkg::CM_W-1:0];

  assign duty_sum = {1'b0, div_quo[urds_pkg::CM_W-1:0]} + (urds_pkg::CM_W+1)'(duty_offset_q);
  always_comb begin
    if (prod_q == '0) begin
      duty_res = urds_pkg::DUTY_MAX;
    end else if (duty_sum > (urds_pkg::CM_W+1)'(urds_pkg::DUTY_MAX)) begin
      duty_res = urds_pkg::DUTY_MAX;
    end else begin
      duty_res = duty_sum[urds_pkg::DUTY_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.div_start && !cmd_i.div_sel) uch_q <= ch_q;
    if (cmd_i.cm_load) cm_q <= cm_sat;
    if (cmd_i.mul_load) begin
      prod_q <= urds_pkg::DVS_W'(gain_den_q) * urds_pkg::DVS_W'(cm_q);
    end
  end

  // Result registers hold the request until the consumer takes it.
  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load_tick) begin
      trigger_lines_o  <= (phase_q == urds_pkg::PH_WAIT || phase_q == urds_pkg::PH_MEAS)
                          ? '0 : urds_pkg::ECHO_W'(1) << ch_q;
      update_valid_o   <= 1'b0;
      update_channel_o <= '0;
      distance_cm_o    <= '0;
      duty_value_o     <= '0;
    end else if (cmd_i.out_load_meas) begin
      trigger_lines_o  <= '0;
      update_valid_o   <= 1'b1;
      update_channel_o <= uch_q;
      distance_cm_o    <= cm_q;
      duty_value_o     <= duty_res;
    end
  end

endmodule

>>> design/ultrasonic_ranging_duty_sequencer_core.sv
// Top level of the four-channel ultrasonic ranging and duty sequencer.
// A tick that ends no measurement gives its result request in the cycle after it is taken.
// A tick that ends a measurement gives its result once the shared restoring divider has run twice,
// retiring one quotient bit per cycle; no further tick is taken until that result is handed off.
// Plain ticks can be taken every cycle while the receiver takes each result request.
// Reset is asynchronous and active low: configuration returns to its defaults, channel 0 in trigger.
module ultrasonic_ranging_duty_sequencer_core #(
  parameter int NUM_CHANNELS = urds_pkg::NUM_CHANNELS_DEF,
  parameter int COUNT_BITS   = urds_pkg::COUNT_BITS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic [urds_pkg::ECHO_W-1:0]     echo_levels_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [urds_pkg::ECHO_W-1:0]     trigger_lines_o,
  output logic                            update_valid_o,
  output logic [urds_pkg::CH_W-1:0]       update_channel_o,
  output logic [urds_pkg::CM_W-1:0]       distance_cm_o,
  output logic [urds_pkg::DUTY_W-1:0]     duty_value_o,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [urds_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [urds_pkg::CFG_DATA_W-1:0] cfg_data_i
);

  urds_pkg::cmd_t cmd;
  urds_pkg::sts_t sts;

  assign cfg_ready_o = 1'b1;

  urds_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_ready_i (out_ready_i),
    .out_valid_o (out_valid_o),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  urds_dp #(
    .NUM_CHANNELS (NUM_CHANNELS),
    .COUNT_BITS   (COUNT_BITS)
  ) u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .echo_levels_i    (echo_levels_i),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i),
    .trigger_lines_o  (trigger_lines_o),
    .update_valid_o   (update_valid_o),
    .update_channel_o (update_channel_o),
    .distance_cm_o    (distance_cm_o),
    .duty_value_o     (duty_value_o)
  );

  // A tick that ends a measurement blocks further ticks while the divisions run.
  a_fin_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && sts.fin) |=> !in_ready_o)
    else $error("tick taken while a measurement result is still being computed");

  // The divider is busy in the cycle after it is started.
  a_div_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.div_start |=> !sts.div_done)
    else $error("divider reports done right after start");

  // A zero distance always maps to the saturated duty.
  a_zero_cm: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && update_valid_o && distance_cm_o == '0) |-> duty_value_o == urds_pkg::DUTY_MAX)
    else $error("zero distance without saturated duty");

  // Ticks without an update carry zero result fields.
  a_idle_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !update_valid_o) |->
      (distance_cm_o == '0 && duty_value_o == '0 && update_channel_o == '0))
    else $error("result fields set on a tick without an update");

endmodule

>>> verif/ultrasonic_ranging_duty_sequencer_checker.sv
`timescale 1ns / 100ps
// Checker that predicts every tick result of the ranging sequencer and compares it.
module ultrasonic_ranging_duty_sequencer_checker #(
  parameter int NUM_CHANNELS = urds_pkg::NUM_CHANNELS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  input  logic                            in_ready_i,
  input  logic [urds_pkg::ECHO_W-1:0]     echo_levels_i,
  input  logic                            out_valid_i,
  input  logic                            out_ready_i,
  input  logic [urds_pkg::ECHO_W-1:0]     trigger_lines_i,
  input  logic                            update_valid_i,
  input  logic [urds_pkg::CH_W-1:0]       update_channel_i,
  input  logic [urds_pkg::CM_W-1:0]       distance_cm_i,
  input  logic [urds_pkg::DUTY_W-1:0]     duty_value_i,
  input  logic                            cfg_valid_i,
  input  logic                            cfg_ready_i,
  input  logic [urds_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [urds_pkg::CFG_DATA_W-1:0] cfg_data_i,
  output int                              fail_count_o,
  output int                              open_count_o,
  output logic [urds_pkg::CH_W-1:0]       next_channel_o
);

  localparam int CNT_W = urds_pkg::COUNT_BITS_DEF;
  localparam int CH_W  = urds_pkg::CH_W;
  localparam int DVS_W = urds_pkg::DVS_W;

  typedef struct packed {
    logic [urds_pkg::ECHO_W-1:0] trig;
    logic                        upd;
    logic [CH_W-1:0]             ch;
    logic [urds_pkg::CM_W-1:0]   cm;
    logic [urds_pkg::DUTY_W-1:0] duty;
  } tick_result_t;

  logic [7:0]        trig_ticks;
  logic [7:0]        ticks_cm;
  logic [15:0]       gain_num;
  logic [7:0]        gain_den;
  logic [7:0]        duty_ofs;
  logic [CH_W-1:0]   chan;
  urds_pkg::phase_e  phase;
  logic [CNT_W-1:0]  count;
  tick_result_t      results_due[$];
  int                errors;

  function automatic logic [urds_pkg::DUTY_W-1:0] duty_for(
      input logic [urds_pkg::CM_W-1:0] cm);
    logic [DVS_W-1:0] dvs;
    logic [DVS_W-1:0] sum;
    dvs = DVS_W'(gain_den) * DVS_W'(cm);
    if (dvs == '0) return urds_pkg::DUTY_MAX;
    sum = (DVS_W'(gain_num) / dvs) + DVS_W'(duty_ofs);
    return (sum > DVS_W'(urds_pkg::DUTY_MAX)) ? urds_pkg::DUTY_MAX
                                              : sum[urds_pkg::DUTY_W-1:0];
  endfunction

  task automatic predict_tick(input logic [urds_pkg::ECHO_W-1:0] lv, output tick_result_t r);
    logic        echo;
    logic [31:0] quot;
    r = '0;
    echo = lv[chan];
    case (phase)
      urds_pkg::PH_WAIT: begin
        if (echo) begin
          count = CNT_W'(1);
          phase = urds_pkg::PH_MEAS;
        end
      end
      urds_pkg::PH_MEAS: begin
        if (echo) begin
          if (count != '1) count = count + CNT_W'(1);
        end else begin
          // A zero scale saturates the distance instead of dividing.
          quot = (ticks_cm == 8'd0) ? 32'(urds_pkg::CM_MAX) : 32'(count) / 32'(ticks_cm);
          r.cm = (quot > 32'(urds_pkg::CM_MAX)) ? urds_pkg::CM_MAX : quot[urds_pkg::CM_W-1:0];
          r.duty = duty_for(r.cm);
          r.upd = 1'b1;
          r.ch = chan;
          count = '0;
          phase = urds_pkg::PH_TRIG;
          chan = (32'(chan) == 32'(NUM_CHANNELS - 1)) ? '0 : chan + CH_W'(1);
        end
      end
      default: begin
        r.trig = urds_pkg::ECHO_W'(1) << chan;
        count = count + CNT_W'(1);
        if (count >= CNT_W'(trig_ticks)) begin
          count = '0;
          phase = urds_pkg::PH_WAIT;
        end
      end
    endcase
  endtask

  task automatic check_field(input string name, input int unsigned want, input int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      errors++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : watch
    tick_result_t r;
    tick_result_t want;
    if (!rst_ni) begin
      trig_ticks = urds_pkg::TRIGGER_TICKS_RST;
      ticks_cm = urds_pkg::TICKS_PER_CM_RST;
      gain_num = urds_pkg::GAIN_NUM_RST;
      gain_den = urds_pkg::GAIN_DEN_RST;
      duty_ofs = urds_pkg::DUTY_OFFSET_RST;
      chan = '0;
      phase = urds_pkg::PH_TRIG;
      count = '0;
      results_due.delete();
      errors = 0;
      fail_count_o <= 0;
      open_count_o <= 0;
      next_channel_o <= '0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          urds_pkg::REG_TRIGGER_TICKS: trig_ticks = cfg_data_i[7:0];
          urds_pkg::REG_TICKS_PER_CM:  ticks_cm = cfg_data_i[7:0];
          urds_pkg::REG_GAIN_NUM:      gain_num = cfg_data_i;
          urds_pkg::REG_GAIN_DEN:      gain_den = cfg_data_i[7:0];
          urds_pkg::REG_DUTY_OFFSET:   duty_ofs = cfg_data_i[7:0];
          default: ;
        endcase
      end
      if (in_valid_i && in_ready_i) begin
        predict_tick(echo_levels_i, r);
        results_due.push_back(r);
      end
      if (out_valid_i && out_ready_i) begin
        if (results_due.size() == 0) begin
          $error("result request with no tick waiting for it");
          errors++;
        end else begin
          want = results_due.pop_front();
          check_field("trigger_lines", 32'(want.trig), 32'(trigger_lines_i));
          check_field("update_valid", 32'(want.upd), 32'(update_valid_i));
          check_field("update_channel", 32'(want.ch), 32'(update_channel_i));
          check_field("distance_cm", 32'(want.cm), 32'(distance_cm_i));
          check_field("duty_value", 32'(want.duty), 32'(duty_value_i));
        end
      end
      fail_count_o <= errors;
      open_count_o <= results_due.size();
      next_channel_o <= chan;
    end
  end

endmodule

>>> verif/ultrasonic_ranging_duty_sequencer_core_test.sv
`timescale 1ns / 100ps
// Testbench top: drives echo ticks and register writes into the sequencer and gives the verdict.
module ultrasonic_ranging_duty_sequencer_core_test;

  localparam int CYCLE_LIMIT = 2_000_000;
  localparam int PHASE_TICKS = 150;
  localparam int LONG_HOLD   = 300;
  localparam int DRAIN_WAIT  = 40;
  localparam int ECHO_W      = urds_pkg::ECHO_W;
  localparam int CH_W        = urds_pkg::CH_W;
  localparam int IDX_W       = urds_pkg::CFG_IDX_W;
  localparam int DATA_W      = urds_pkg::CFG_DATA_W;

  logic                        clk = 1'b0;
  logic                        rst_n = 1'b0;
  logic                        in_valid = 1'b0;
  logic                        in_ready;
  logic [ECHO_W-1:0]           echo_levels = '0;
  logic                        out_valid;
  logic                        out_ready = 1'b1;
  logic [ECHO_W-1:0]           trigger_lines;
  logic                        update_valid;
  logic [CH_W-1:0]             update_channel;
  logic [urds_pkg::CM_W-1:0]   distance_cm;
  logic [urds_pkg::DUTY_W-1:0] duty_value;
  logic                        cfg_valid = 1'b0;
  logic                        cfg_ready;
  logic [IDX_W-1:0]            cfg_index = '0;
  logic [DATA_W-1:0]           cfg_data = '0;

  int              fail_count;
  int              open_count;
  logic [CH_W-1:0] next_channel;

  logic [7:0]      trig_set = urds_pkg::TRIGGER_TICKS_RST;
  logic [CH_W-1:0] ch_track = '0;
  bit              tx_idle = 1'b0;
  int              burst_left = 0;
  int              sent = 0;
  bit              rx_random = 1'b0;
  int              rx_left = 0;
  int              hold_left = 0;
  int              hold_ask = 0;
  int              hold_seen = 0;
  int              cycle_count = 0;

  always #2 clk = ~clk;

  ultrasonic_ranging_duty_sequencer_core u_top (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .in_valid_i       (in_valid),
    .in_ready_o       (in_ready),
    .echo_levels_i    (echo_levels),
    .out_valid_o      (out_valid),
    .out_ready_i      (out_ready),
    .trigger_lines_o  (trigger_lines),
    .update_valid_o   (update_valid),
    .update_channel_o (update_channel),
    .distance_cm_o    (distance_cm),
    .duty_value_o     (duty_value),
    .cfg_valid_i      (cfg_valid),
    .cfg_ready_o      (cfg_ready),
    .cfg_index_i      (cfg_index),
    .cfg_data_i       (cfg_data)
  );

  ultrasonic_ranging_duty_sequencer_checker u_checker (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .in_valid_i       (in_valid),
    .in_ready_i       (in_ready),
    .echo_levels_i    (echo_levels),
    .out_valid_i      (out_valid),
    .out_ready_i      (out_ready),
    .trigger_lines_i  (trigger_lines),
    .update_valid_i   (update_valid),
    .update_channel_i (update_channel),
    .distance_cm_i    (distance_cm),
    .duty_value_i     (duty_value),
    .cfg_valid_i      (cfg_valid),
    .cfg_ready_i      (cfg_ready),
    .cfg_index_i      (cfg_index),
    .cfg_data_i       (cfg_data),
    .fail_count_o     (fail_count),
    .open_count_o     (open_count),
    .next_channel_o   (next_channel)
  );

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // Receiver: alternating runs of ready and stall, plus a long hold-off on request.
  always @(posedge clk) begin
    if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_ready <= (hold_left == 1);
    end else if (hold_ask != hold_seen) begin
      hold_seen <= hold_ask;
      hold_left <= LONG_HOLD;
      out_ready <= 1'b0;
    end else if (!rx_random) begin
      out_ready <= 1'b1;
    end else if (rx_left > 0) begin
      rx_left <= rx_left - 1;
    end else begin
      out_ready <= !out_ready;
      rx_left <= out_ready ? int'($urandom_range(0, 5)) : int'($urandom_range(0, 12));
    end
  end

  function automatic logic [ECHO_W-1:0] rand_levels();
    return ECHO_W'($urandom_range(0, 15));
  endfunction

  task automatic send_tick(input logic [ECHO_W-1:0] lv);
    if (tx_idle) begin
      if (burst_left == 0) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk);
        burst_left = int'($urandom_range(1, 24));
      end
      burst_left--;
    end
    in_valid <= 1'b1;
    echo_levels <= lv;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sent++;
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (open_count != 0) @(posedge clk);
  endtask

  task automatic cfg_put(input logic [IDX_W-1:0] idx, input logic [DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  // The upper byte of the 8-bit registers carries junk that must be dropped.
  task automatic cfg_load(input logic [7:0] tt, input logic [7:0] tpc, input logic [15:0] gn,
                          input logic [7:0] gd, input logic [7:0] off);
    logic [IDX_W-1:0] spare;
    spare = IDX_W'(32'(urds_pkg::REG_DUTY_OFFSET) + 32'd1 + ($urandom % 3));
    cfg_put(urds_pkg::REG_TRIGGER_TICKS, {8'($urandom), tt});
    cfg_put(urds_pkg::REG_TICKS_PER_CM, {8'($urandom), tpc});
    cfg_put(urds_pkg::REG_GAIN_NUM, gn);
    cfg_put(urds_pkg::REG_GAIN_DEN, {8'($urandom), gd});
    cfg_put(urds_pkg::REG_DUTY_OFFSET, {8'($urandom), off});
    cfg_put(spare, 16'($urandom));
    cfg_valid <= 1'b0;
    trig_set = tt;
  endtask

  // One full measurement of the active channel: trigger, wait, echo high, echo low.
  task automatic measure(input int wait_n, input int high_n);
    int                n_trig;
    logic [ECHO_W-1:0] mask;
    n_trig = (trig_set == 8'd0) ? 1 : int'(trig_set);
    mask = ECHO_W'(1) << ch_track;
    repeat (n_trig) send_tick(rand_levels());
    repeat (wait_n) send_tick(rand_levels() & ~mask);
    repeat (high_n) send_tick(rand_levels() | mask);
    send_tick(rand_levels() & ~mask);
    ch_track = (32'(ch_track) == 32'(urds_pkg::NUM_CHANNELS_DEF - 1)) ? '0
                                                                      : ch_track + CH_W'(1);
  endtask

  // Random echo levels, then all echoes high long enough to reach the measure phase
  // from anywhere, then all low, which leaves the block in the trigger phase.
  task automatic noise_burst(input int n);
    int n_trig;
    n_trig = (trig_set == 8'd0) ? 1 : int'(trig_set);
    repeat (n) send_tick(rand_levels());
    repeat (n_trig + 1) send_tick(4'hF);
    send_tick(4'h0);
    drain_results();
    ch_track = next_channel;
  endtask

  initial begin
    int          p;
    int          start;
    int          r;
    int          hn;
    logic [7:0]  tt;
    logic [7:0]  tpc;
    logic [7:0]  gd;
    logic [7:0]  off;
    logic [15:0] gn;

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: defaults with a short echo, so the distance is zero and the duty saturates.
    tx_idle = 1'b1;
    measure(0, 3);
    drain_results();
    // Zero trigger length acts as one tick.
    cfg_load(8'd0, 8'd1, 16'd128, 8'd3, 8'd13);
    measure(0, 2);
    drain_results();
    // Zero ticks per centimeter saturates the distance.
    cfg_load(8'd0, 8'd0, 16'hFFFF, 8'd255, 8'd255);
    measure(1, 1);
    drain_results();
    // Zero gain divisor saturates the duty.
    cfg_load(8'd0, 8'd1, 16'hFFFF, 8'd0, 8'd0);
    measure(0, 1);
    drain_results();
    // Zero gain gives the bare offset.
    cfg_load(8'd0, 8'd1, 16'd0, 8'd1, 8'd0);
    measure(0, 3);
    drain_results();

    for (p = 0; p < 10; p++) begin
      drain_results();
      case (p)
        0: cfg_load(8'd255, 8'd255, 16'hFFFF, 8'd255, 8'd255);
        1: cfg_load(8'd1, 8'd1, 16'd1, 8'd1, 8'd0);
        default: begin
          tt = 8'($urandom_range(0, 12));
          tpc = (p % 2 != 0) ? 8'($urandom_range(1, 8)) : 8'($urandom_range(0, 255));
          gn = 16'($urandom);
          gd = ($urandom_range(0, 9) == 0) ? 8'd0 : 8'($urandom_range(1, 255));
          off = 8'($urandom_range(0, 255));
          cfg_load(tt, tpc, gn, gd, off);
        end
      endcase
      tx_idle = (p % 3 != 2);
      rx_random <= (p % 3 != 2);
      if (p == 3) hold_ask <= hold_ask + 1;
      start = sent;
      while (sent - start < PHASE_TICKS) begin
        if ($urandom_range(0, 99) < 85) begin
          r = int'($urandom_range(0, 99));
          hn = (r < 70) ? int'($urandom_range(1, 10)) :
               (r < 95) ? int'($urandom_range(11, 100)) : int'($urandom_range(101, 600));
          measure(int'($urandom_range(0, 4)), hn);
        end else begin
          noise_burst(int'($urandom_range(1, 20)));
        end
      end
    end

    drain_results();
    repeat (DRAIN_WAIT) @(posedge clk);
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
